FILE: sv/shape_pair_collision_faces_top_defines.svh
// Assertion macros for the shape pair collision block.
`ifndef SHAPE_PAIR_COLLISION_FACES_TOP_DEFINES_SVH
`define SHAPE_PAIR_COLLISION_FACES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define SPCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define SPCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPCF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/spcf_pkg.sv
package spcf_pkg;

    // Largest number of edge samples taken per direction.
    localparam int MaxSamples = 64;
    localparam int SampW = $clog2(MaxSamples + 1);

    // Margin taken off the first rectangle's size to form the sample step.
    localparam logic signed [22:0] EdgeMargin = 23'sd32;

    // Command codes.
    localparam logic [1:0] CMD_RR = 2'd0;
    localparam logic [1:0] CMD_CR = 2'd1;
    localparam logic [1:0] CMD_CC = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Face mask bits.
    localparam int F_LT = 0;
    localparam int F_RT = 1;
    localparam int F_LB = 2;
    localparam int F_RB = 3;
    localparam int F_TOP = 4;
    localparam int F_BOT = 5;
    localparam int F_LEFT = 6;
    localparam int F_RIGHT = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new input beat
        logic prep;     // build boxes and overlap terms
        logic circ;     // compute circle distance products
        logic corners;  // test corners, settle overlap
        logic hinit;    // start the horizontal sampling pass
        logic vinit;    // start the vertical sampling pass
        logic sample;   // take one sample in the current pass
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_done;  // current sampling pass has no more samples
        logic h_needed;   // A narrower than B
        logic v_needed;   // A shorter than B
    } t_sts;

endpackage

FILE: sv/spcf_ctrl.sv
`include "shape_pair_collision_faces_top_defines.svh"

module spcf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output spcf_pkg::t_cmd  o_cmd,
    input  spcf_pkg::t_sts  i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_CIRC = 3'd2;
    localparam logic [2:0] S_CORN = 3'd3;
    localparam logic [2:0] S_HORZ = 3'd4;
    localparam logic [2:0] S_VERT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_CIRC;
            end
            S_CIRC: begin
                o_cmd.circ = 1'b1;
                n_state = S_CORN;
            end
            S_CORN: begin
                o_cmd.corners = 1'b1;
                o_cmd.hinit = 1'b1;
                n_state = S_HORZ;
            end
            S_HORZ: begin
                if (i_sts.h_needed && !i_sts.pass_done) begin
                    o_cmd.sample = 1'b1;
                end else begin
                    o_cmd.vinit = 1'b1;
                    n_state = S_VERT;
                end
            end
            S_VERT: begin
                if (i_sts.v_needed && !i_sts.pass_done) begin
                    o_cmd.sample = 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SPCF_ASSERT_NEXT(a_load_to_prep, i_clk, i_rst_n, o_cmd.load, r_state == S_PREP)
    `SPCF_ASSERT_IMP(a_no_take_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `SPCF_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule

FILE: sv/spcf_dpath.sv
`include "shape_pair_collision_faces_top_defines.svh"

module spcf_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spcf_pkg::t_cmd      i_cmd,
    output spcf_pkg::t_sts      o_sts,
    input  logic [1:0]          i_cmd_code,
    input  logic signed [19:0]  i_a_x,
    input  logic signed [19:0]  i_a_y,
    input  logic [15:0]         i_a_w,
    input  logic [15:0]         i_a_h,
    input  logic [14:0]         i_a_radius,
    input  logic signed [19:0]  i_b_x,
    input  logic signed [19:0]  i_b_y,
    input  logic [15:0]         i_b_w,
    input  logic [15:0]         i_b_h,
    input  logic [14:0]         i_b_radius,
    output logic                o_overlap,
    output logic [7:0]          o_faces
);

    // Captured input beat.
    logic [1:0]         r_op;
    logic signed [19:0] r_ax, r_ay, r_bx, r_by;
    logic [15:0]        r_aw, r_ah, r_bw, r_bh;
    logic [14:0]        r_ar, r_br;

    // Boxes for the face test, 23-bit signed covers every sum.
    logic signed [22:0] r_pax, r_pay, r_paw, r_pah;
    logic signed [22:0] r_pbx, r_pby, r_pbw, r_pbh;
    logic               r_box_ov, r_in_wide, r_in_tall;

    // Squared distance terms.
    logic [41:0] r_sq_ab, r_sq_rs;
    logic [41:0] r_sq_c0, r_sq_c1, r_sq_c2, r_sq_c3, r_sq_r;
    logic        r_hit;
    logic [7:0]  r_faces;

    // Sampling pass.
    logic signed [22:0] r_step, r_pos;
    logic [spcf_pkg::SampW-1:0] r_cnt;
    logic        r_vert;

    logic signed [22:0] pax, pay, paw, pah, pbx, pby, pbw, pbh;
    logic signed [22:0] ar23, br23;
    logic signed [22:0] bxr, byb;
    logic signed [22:0] dx0, dx1, dy0, dy1, dxc, dyc;
    logic signed [22:0] step_raw, bsize;
    logic               pass_done;
    logic signed [22:0] spx1, spy1, spx2, spy2;
    logic               hit1, hit2;

    // Point inside box, inclusive on all sides.
    function automatic logic in_box(input logic signed [22:0] px, input logic signed [22:0] py,
                                    input logic signed [22:0] bx, input logic signed [22:0] by,
                                    input logic signed [22:0] bw, input logic signed [22:0] bh);
        in_box = (bx <= px) && (bx + bw >= px) && (by <= py) && (by + bh >= py);
    endfunction

    function automatic logic [41:0] sq(input logic signed [22:0] v);
        logic [21:0] m;
        m = v[22] ? 22'(-v) : v[21:0];
        sq = 42'(m) * 42'(m);
    endfunction

    assign ar23 = 23'(signed'({1'b0, r_ar}));
    assign br23 = 23'(signed'({1'b0, r_br}));

    // Box of A and B as the face test sees them.
    always_comb begin
        if (r_op == spcf_pkg::CMD_RR) begin
            pax = 23'(r_ax);
            pay = 23'(r_ay);
            paw = 23'(signed'({1'b0, r_aw}));
            pah = 23'(signed'({1'b0, r_ah}));
        end else begin
            pax = 23'(r_ax) - ar23;
            pay = 23'(r_ay) - ar23;
            paw = ar23 <<< 1;
            pah = ar23 <<< 1;
        end
        if (r_op == spcf_pkg::CMD_CC) begin
            pbx = 23'(r_bx) - br23;
            pby = 23'(r_by) - br23;
            pbw = br23 <<< 1;
            pbh = br23 <<< 1;
        end else begin
            pbx = 23'(r_bx);
            pby = 23'(r_by);
            pbw = 23'(signed'({1'b0, r_bw}));
            pbh = 23'(signed'({1'b0, r_bh}));
        end
    end

    // Circle centre deltas to B's corners and to the other centre.
    assign bxr = r_pbx + r_pbw;
    assign byb = r_pby + r_pbh;
    assign dx0 = 23'(r_ax) - r_pbx;
    assign dx1 = 23'(r_ax) - bxr;
    assign dy0 = 23'(r_ay) - r_pby;
    assign dy1 = 23'(r_ay) - byb;
    assign dxc = 23'(r_ax) - 23'(r_bx);
    assign dyc = 23'(r_ay) - 23'(r_by);

    // Step of the current pass and B's size along it.
    assign step_raw = (r_vert ? r_pah : r_paw) - spcf_pkg::EdgeMargin;
    assign bsize = r_vert ? r_pbh : r_pbw;
    assign pass_done = (r_cnt == spcf_pkg::SampW'(spcf_pkg::MaxSamples)) || (r_pos >= bsize);

    assign o_sts.pass_done = pass_done;
    assign o_sts.h_needed = r_paw < r_pbw;
    assign o_sts.v_needed = r_pah < r_pbh;

    // Sample points of the current pass.
    assign spx1 = r_vert ? bxr : r_pbx + r_pos;
    assign spy1 = r_vert ? r_pby + r_pos : r_pby;
    assign spx2 = r_vert ? r_pbx : r_pbx + r_pos;
    assign spy2 = r_vert ? r_pby + r_pos : byb;
    assign hit1 = in_box(spx1, spy1, r_pax, r_pay, r_paw, r_pah);
    assign hit2 = in_box(spx2, spy2, r_pax, r_pay, r_paw, r_pah);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_cmd_code;
            r_ax <= i_a_x;
            r_ay <= i_a_y;
            r_aw <= i_a_w;
            r_ah <= i_a_h;
            r_ar <= i_a_radius;
            r_bx <= i_b_x;
            r_by <= i_b_y;
            r_bw <= i_b_w;
            r_bh <= i_b_h;
            r_br <= i_b_radius;
        end
        if (i_cmd.prep) begin
            r_pax <= pax;
            r_pay <= pay;
            r_paw <= paw;
            r_pah <= pah;
            r_pbx <= pbx;
            r_pby <= pby;
            r_pbw <= pbw;
            r_pbh <= pbh;
            r_box_ov <= !((pax - (pbx + pbw) > 0) || (pbx - (pax + paw) > 0) ||
                          (pay - (pby + pbh) > 0) || (pby - (pay + pah) > 0));
            r_in_wide <= in_box(23'(r_ax), 23'(r_ay), pbx - ar23, pby, pbw + (ar23 <<< 1), pbh);
            r_in_tall <= in_box(23'(r_ax), 23'(r_ay), pbx, pby - ar23, pbw, pbh + (ar23 <<< 1));
        end
        if (i_cmd.circ) begin
            r_sq_ab <= sq(dxc) + sq(dyc);
            r_sq_rs <= sq(ar23 + br23);
            r_sq_c0 <= sq(dx0) + sq(dy0);
            r_sq_c1 <= sq(dx1) + sq(dy0);
            r_sq_c2 <= sq(dx0) + sq(dy1);
            r_sq_c3 <= sq(dx1) + sq(dy1);
            r_sq_r <= sq(ar23);
        end
        // Corners and overlap.
        if (i_cmd.corners) begin
            r_faces <= '0;
            r_faces[spcf_pkg::F_LT] <= in_box(r_pbx, r_pby, r_pax, r_pay, r_paw, r_pah);
            r_faces[spcf_pkg::F_RT] <= in_box(bxr, r_pby, r_pax, r_pay, r_paw, r_pah);
            r_faces[spcf_pkg::F_LB] <= in_box(r_pbx, byb, r_pax, r_pay, r_paw, r_pah);
            r_faces[spcf_pkg::F_RB] <= in_box(bxr, byb, r_pax, r_pay, r_paw, r_pah);
            case (r_op)
                spcf_pkg::CMD_RR: r_hit <= r_box_ov;
                spcf_pkg::CMD_CR: r_hit <= r_in_wide || r_in_tall ||
                    (r_sq_c0 <= r_sq_r) || (r_sq_c1 <= r_sq_r) ||
                    (r_sq_c2 <= r_sq_r) || (r_sq_c3 <= r_sq_r);
                spcf_pkg::CMD_CC: r_hit <= (r_sq_ab <= r_sq_rs);
                default: r_hit <= 1'b0;
            endcase
        end
        // Pass start: records the pass direction; the step, set below, is kept at least one LSB.
        if (i_cmd.hinit || i_cmd.vinit) begin
            r_vert <= i_cmd.vinit;
        end
        if (i_cmd.sample) begin
            if (r_vert) begin
                if (hit1) r_faces[spcf_pkg::F_RIGHT] <= 1'b1;
                if (hit2) r_faces[spcf_pkg::F_LEFT] <= 1'b1;
            end else begin
                if (hit1) r_faces[spcf_pkg::F_TOP] <= 1'b1;
                if (hit2) r_faces[spcf_pkg::F_BOT] <= 1'b1;
            end
        end
    end

    // Sample counter, cleared on each pass start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.hinit || i_cmd.vinit) begin
            r_cnt <= '0;
        end else if (i_cmd.sample) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    logic signed [22:0] step_h, step_v, step_sel;
    assign step_h = r_paw - spcf_pkg::EdgeMargin;
    assign step_v = r_pah - spcf_pkg::EdgeMargin;
    assign step_sel = i_cmd.vinit ? step_v : step_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.hinit || i_cmd.vinit) begin
            r_step <= (step_sel < 23'sd1) ? 23'sd1 : step_sel;
            r_pos <= (step_sel < 23'sd1) ? 23'sd1 : step_sel;
        end else if (i_cmd.sample) begin
            r_pos <= r_pos + r_step;
        end
    end

    assign o_overlap = r_hit;
    assign o_faces = ((r_op == spcf_pkg::CMD_RR) || r_hit) ? r_faces : 8'd0;

    `SPCF_ASSERT_IMP(a_sample_bounded, i_clk, i_rst_n, i_cmd.sample,
        r_cnt < spcf_pkg::SampW'(spcf_pkg::MaxSamples))
    `SPCF_ASSERT_IMP(a_step_positive, i_clk, i_rst_n, i_cmd.sample, r_step > 23'sd0)
    `SPCF_ASSERT_IMP(a_step_unused, i_clk, i_rst_n, i_cmd.sample && step_raw > 23'sd0,
        r_step == step_raw)

endmodule

FILE: sv/shape_pair_collision_faces_top.sv
// Channel  Direction  Handshake            Payload
// input    in         i_in_valid/o_in_stall  cmd, shape A, shape B
// output   out        o_out_valid/i_out_stall overlap, faces
//
// After the accepting edge the controller runs prep, circle, corner, then the horizontal
// and vertical sampling passes, each of at most 64 sample steps, before presenting the result.
// The sampling sequencer takes one point pair per cycle.
// Reset is synchronous, active low, and returns the controller to idle.
// The result is held while the output is stalled; no new beat is taken until it goes.

module shape_pair_collision_faces_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic signed [19:0]  i_a_x,
    input  logic signed [19:0]  i_a_y,
    input  logic [15:0]         i_a_w,
    input  logic [15:0]         i_a_h,
    input  logic [14:0]         i_a_radius,
    input  logic signed [19:0]  i_b_x,
    input  logic signed [19:0]  i_b_y,
    input  logic [15:0]         i_b_w,
    input  logic [15:0]         i_b_h,
    input  logic [14:0]         i_b_radius,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_overlap,
    output logic [7:0]          o_faces
);

    spcf_pkg::t_cmd cmd;
    spcf_pkg::t_sts sts;

    // Sequencer.
    spcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Geometry datapath.
    spcf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cmd_code (i_cmd),
        .i_a_x      (i_a_x),
        .i_a_y      (i_a_y),
        .i_a_w      (i_a_w),
        .i_a_h      (i_a_h),
        .i_a_radius (i_a_radius),
        .i_b_x      (i_b_x),
        .i_b_y      (i_b_y),
        .i_b_w      (i_b_w),
        .i_b_h      (i_b_h),
        .i_b_radius (i_b_radius),
        .o_overlap  (o_overlap),
        .o_faces    (o_faces)
    );

endmodule
